// ===== sv/assert_macros.svh =====
// assertion helpers for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== sv/mmcs_pkg.sv =====
package mmcs_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_OUT_LOW  = 1'b0;
    localparam logic [IDX_W-1:0] REG_OUT_HIGH = 1'b1;

    localparam logic [DATA_W-1:0] OUT_LOW_RST  = DATA_W'(0);
    localparam logic [DATA_W-1:0] OUT_HIGH_RST = DATA_W'(255);

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_MAP     = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] sample_value;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] mapped_value;
        logic              flat_range;
    } t_out_item;

    typedef struct packed {
        logic measure;
        logic load;
        logic mul;
        logic step;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic flat;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/mmcs_ctrl.sv =====
module mmcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_action,
    input  mmcs_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output mmcs_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [mmcs_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == mmcs_pkg::ACT_MEASURE) begin
                        o_cmd.measure = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = i_stat.flat ? S_DONE : S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == {mmcs_pkg::CNT_W{1'b1}}) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/mmcs_dp.sv =====
module mmcs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mmcs_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [mmcs_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  mmcs_pkg::t_in_item                  i_in_item,
    input  mmcs_pkg::t_dp_cmd                   i_cmd,
    output mmcs_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mmcs_pkg::t_out_item                 o_out_item
);

    localparam int DW = mmcs_pkg::DATA_W;

    logic [DW-1:0]   r_out_low, r_out_high;
    logic [DW-1:0]   r_seen_min, r_seen_max;
    logic            r_seen_any;
    logic [DW-1:0]   r_d, r_r, r_s;
    logic            r_inv, r_flat;
    logic [DW-1:0]   r_rem, r_quo;
    logic            r_out_valid;
    mmcs_pkg::t_out_item r_out;

    logic [DW-1:0]   w_v, w_vc;
    logic [mmcs_pkg::PROD_W-1:0] w_prod;
    logic [DW:0]     w_trial, w_diff;
    logic            w_ge;
    logic [DW-1:0]   w_result;

    assign w_v = i_in_item.sample_value;

    // clamp into the measured range
    always_comb begin
        if (w_v < r_seen_min) begin
            w_vc = r_seen_min;
        end else if (w_v > r_seen_max) begin
            w_vc = r_seen_max;
        end else begin
            w_vc = w_v;
        end
    end

    assign o_stat.flat     = !r_seen_any || (r_seen_max <= r_seen_min);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign w_prod  = mmcs_pkg::PROD_W'(r_d) * mmcs_pkg::PROD_W'(r_s);
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_r};
    assign w_ge    = (w_trial >= {1'b0, r_r});

    always_comb begin
        if (r_flat) begin
            w_result = r_seen_max;
        end else if (r_inv) begin
            w_result = r_out_low - r_quo - DW'(r_rem != '0);
        end else begin
            w_result = r_out_low + r_quo;
        end
    end

    // config registers and measured bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_low  <= mmcs_pkg::OUT_LOW_RST;
            r_out_high <= mmcs_pkg::OUT_HIGH_RST;
            r_seen_min <= '1;
            r_seen_max <= '0;
            r_seen_any <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    mmcs_pkg::REG_OUT_LOW:  r_out_low  <= i_cfg_wdata;
                    mmcs_pkg::REG_OUT_HIGH: r_out_high <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.measure) begin
                r_seen_any <= 1'b1;
                if (i_in_item.frame_start || !r_seen_any) begin
                    r_seen_min <= w_v;
                    r_seen_max <= w_v;
                end else begin
                    if (w_v < r_seen_min) r_seen_min <= w_v;
                    if (w_v > r_seen_max) r_seen_max <= w_v;
                end
            end
        end
    end

    // operand, multiply and restoring divide registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d    <= w_vc - r_seen_min;
            r_r    <= r_seen_max - r_seen_min;
            r_inv  <= (r_out_high < r_out_low);
            r_s    <= (r_out_high < r_out_low) ? (r_out_low - r_out_high)
                                               : (r_out_high - r_out_low);
            r_flat <= o_stat.flat;
        end
        if (i_cmd.mul) begin
            r_rem <= w_prod[mmcs_pkg::PROD_W-1:DW];
            r_quo <= w_prod[DW-1:0];
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.mapped_value <= w_result;
            r_out.flat_range   <= r_flat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/min_max_contrast_stretch_unit.sv =====
// min/max contrast stretch over 16-bit unsigned samples
// input beats (valid/ready) carry action, sample_value and frame_start;
// measure beats fold the sample into the running min and max (frame_start
// restarts both), map beats rescale the clamped sample from [min, max] to
// [out_low, out_high], either direction, truncated
// output beats (valid/ready) carry mapped_value and flat_range, one per map
// beat; a flat or unmeasured range gives the measured max with flat_range set
// map beats reach the output register after a 16x16 multiply, 16 steps of
// the restoring divider (one quotient bit per cycle), then the result load;
// a flat map beat skips the multiply and the divider
// the block works on one beat at a time; input ready is low from a map
// accept until its result is loaded, so a new map beat waits for the last
// one's result, and measure beats (no output) run at one per cycle
// the output register holds a finished beat while the receiver stalls and
// new beats are accepted meanwhile; a later map result waits, with input
// ready low, until it drains
// config writes (out_low index 0, out_high index 1) are registered
// reset (synchronous, active low) clears min to all ones, max to zero,
// forgets any measurement, sets out_low 0 and out_high 255, empties output
`include "assert_macros.svh"

module min_max_contrast_stretch_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mmcs_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [mmcs_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mmcs_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mmcs_pkg::t_out_item           o_out_item
);

    mmcs_pkg::t_dp_cmd  w_cmd;
    mmcs_pkg::t_dp_stat w_stat;

    mmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mmcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // a map beat occupies the block
    `ASSERT_CLK(a_map_busy, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && i_in_item.action == mmcs_pkg::ACT_MAP) |=> !o_in_ready)
    // a measure beat leaves the block ready
    `ASSERT_CLK(a_measure_ready, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && i_in_item.action == mmcs_pkg::ACT_MEASURE) |=> o_in_ready)
    // a new output beat is loaded only from the finishing state
    `ASSERT_CLK(a_push_when_busy, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(!o_in_ready))
    // no command pulse on an idle block without an input beat
    `ASSERT_NEVER(a_no_stray_load, i_clk, i_rst_n,
        (w_cmd.load || w_cmd.measure) && !(i_in_valid && o_in_ready))

endmodule
